@@ sv/ssc_pkg.sv @@
package ssc_pkg;

  localparam int unsigned ValW          = 11;
  localparam int unsigned StackDepthDef = 1024;
  localparam logic [ValW-1:0] MaxValueRst = 11'd1024;

  // one run of consecutive pushed values, lo at the bottom
  typedef struct packed {
    logic [ValW-1:0] lo;
    logic [ValW-1:0] hi;
  } run_t;

endpackage

@@ sv/ssc_in_if.sv @@
interface ssc_in_if
  import ssc_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [ValW-1:0] value;
  logic            first_item;

  modport source (output valid, output value, output first_item, input ready);
  modport sink   (input valid, input value, input first_item, output ready);
endinterface

@@ sv/ssc_out_if.sv @@
interface ssc_out_if
  import ssc_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [ValW-1:0] push_count;
  logic            popped;
  logic            failed;

  modport source (output valid, output push_count, output popped, output failed, input ready);
  modport sink   (input valid, input push_count, input popped, input failed, output ready);
endinterface

@@ sv/ssc_run_mem.sv @@
module ssc_run_mem
  import ssc_pkg::*;
#(
  parameter int unsigned Depth = StackDepthDef,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  run_t             wr_run_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output run_t             rd_run_o
);

  run_t mem_q [Depth];
  run_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_run_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_run_o = rd_q;

endmodule

@@ sv/ssc_ctrl.sv @@
module ssc_ctrl
  import ssc_pkg::*;
#(
  parameter int unsigned StackDepth = StackDepthDef,
  localparam int unsigned AddrW = $clog2(StackDepth),
  localparam int unsigned CntW  = $clog2(StackDepth) + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ValW-1:0]  max_value_i,
  ssc_in_if.sink           in_i,
  ssc_out_if.source        out_o,
  output logic             mem_wr_en_o,
  output logic [AddrW-1:0] mem_wr_addr_o,
  output run_t             mem_wr_run_o,
  output logic             mem_rd_en_o,
  output logic [AddrW-1:0] mem_rd_addr_o,
  input  run_t             mem_rd_run_i
);

  typedef enum logic {StIdle, StFill} state_e;

  localparam int unsigned CapInt = (StackDepth > 2047) ? 2047 : StackDepth;
  localparam logic [ValW-1:0] DepthCap = ValW'(CapInt);

  state_e          state_q, state_d;
  logic [ValW-1:0] last_q, last_d;
  logic [ValW-1:0] top_lo_q, top_lo_d;
  logic [ValW-1:0] top_hi_q, top_hi_d;
  logic            top_vld_q, top_vld_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            fail_q, fail_d;
  logic            out_vld_q, out_vld_d;
  logic [ValW-1:0] out_cnt_q, out_cnt_d;
  logic            out_pop_q, out_pop_d;
  logic            out_fail_q, out_fail_d;

  logic            accept;
  logic [ValW-1:0] want, limit, last_eff;
  logic            top_vld_eff, fail_eff;
  logic [CntW-1:0] cnt_eff;
  logic            do_push, do_pop, new_run;

  assign in_i.ready = (state_q == StIdle) && (!out_vld_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;
  assign want       = in_i.value;
  assign limit      = (max_value_i < DepthCap) ? max_value_i : DepthCap;

  // first_item clears the state ahead of its own beat
  assign last_eff    = in_i.first_item ? '0 : last_q;
  assign top_vld_eff = in_i.first_item ? 1'b0 : top_vld_q;
  assign cnt_eff     = in_i.first_item ? '0 : cnt_q;
  assign fail_eff    = in_i.first_item ? 1'b0 : fail_q;

  // pushes always reach the wanted value, so a push is always followed by its pop
  assign do_push = (want > last_eff) && (want <= limit);
  assign do_pop  = (want <= last_eff) && top_vld_eff && (top_hi_q == want);
  assign new_run = do_push && (want != ValW'(last_eff + 1'b1));

  always_comb begin
    state_d    = state_q;
    last_d     = last_q;
    top_lo_d   = top_lo_q;
    top_hi_d   = top_hi_q;
    top_vld_d  = top_vld_q;
    cnt_d      = cnt_q;
    fail_d     = fail_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_cnt_d  = out_cnt_q;
    out_pop_d  = out_pop_q;
    out_fail_d = out_fail_q;

    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = cnt_eff[AddrW-1:0];
    mem_wr_run_o  = '{lo: top_lo_q, hi: top_hi_q};
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = AddrW'(cnt_eff - 1'b1);

    case (state_q)
      StIdle: begin
        if (accept) begin
          last_d    = do_push ? want : last_eff;
          top_vld_d = top_vld_eff;
          cnt_d     = cnt_eff;
          fail_d    = fail_eff || !(do_push || do_pop);

          if (new_run) begin
            // spill the current top run, the new run sits in registers
            if (top_vld_eff) begin
              mem_wr_en_o = 1'b1;
              cnt_d       = cnt_eff + 1'b1;
            end
            top_lo_d  = ValW'(last_eff + 1'b1);
            top_hi_d  = want - 1'b1;
            top_vld_d = 1'b1;
          end

          if (do_pop) begin
            if (top_hi_q == top_lo_q) begin
              if (cnt_eff != '0) begin
                mem_rd_en_o = 1'b1;
                cnt_d       = cnt_eff - 1'b1;
                state_d     = StFill;
              end else begin
                top_vld_d = 1'b0;
              end
            end else begin
              top_hi_d = top_hi_q - 1'b1;
            end
          end

          out_vld_d  = 1'b1;
          out_cnt_d  = do_push ? (want - last_eff) : '0;
          out_pop_d  = do_push || do_pop;
          out_fail_d = fail_d;
        end
      end
      StFill: begin
        top_lo_d = mem_rd_run_i.lo;
        top_hi_d = mem_rd_run_i.hi;
        state_d  = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      last_q     <= '0;
      top_lo_q   <= '0;
      top_hi_q   <= '0;
      top_vld_q  <= 1'b0;
      cnt_q      <= '0;
      fail_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      out_cnt_q  <= '0;
      out_pop_q  <= 1'b0;
      out_fail_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      last_q     <= last_d;
      top_lo_q   <= top_lo_d;
      top_hi_q   <= top_hi_d;
      top_vld_q  <= top_vld_d;
      cnt_q      <= cnt_d;
      fail_q     <= fail_d;
      out_vld_q  <= out_vld_d;
      out_cnt_q  <= out_cnt_d;
      out_pop_q  <= out_pop_d;
      out_fail_q <= out_fail_d;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.push_count = out_cnt_q;
  assign out_o.popped     = out_pop_q;
  assign out_o.failed     = out_fail_q;

`ifndef ASSERT_OFF
  a_fill_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFill |=> state_q == StIdle)
    else $error("refill took more than one cycle");

  a_no_accept_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFill |-> !in_i.ready)
    else $error("beat accepted during refill");

  a_mem_rd_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_rd_en_o && mem_wr_en_o))
    else $error("run memory read and write in one cycle");

  a_fail_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_pop_q |-> out_cnt_q == '0 && out_fail_q)
    else $error("failed beat carries pushes or no failure");

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_i.first_item && fail_q |=> out_fail_q)
    else $error("failure flag dropped without a clear");
`endif

endmodule

@@ sv/stack_sequence_checker_core.sv @@
// stack sequence checker
// in_i carries one wanted value per beat (value, first_item). The block pushes
// 1, 2, 3, ... onto a stack until the value is on top and pops it; out_o returns
// one beat per input beat with push_count, popped and the sticky failed flag.
// first_item clears stack, counter and failure before its own beat is handled.
// cfg_we_i / cfg_wdata_i write max_value, the largest value that may be pushed
// (clamped to STACK_DEPTH); write it only while the block is idle.
// the result beat is valid the cycle after the input beat is taken.
// throughput: one beat per cycle while out_o is ready; a pop that empties the
// cached top run while older runs sit in memory adds the StFill refill state.
// runs of consecutive values live in a single-port-per-direction memory of
// STACK_DEPTH entries; only the top run is held in registers.
// reset: stack empty, next push is 1, failure cleared, max_value 1024; no
// memory clear is needed.
// when out_o stalls the result waits in the output register and in_i.ready
// stays low; the next beat is taken in the cycle the held result leaves.
module stack_sequence_checker_core
  import ssc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [ValW-1:0] cfg_wdata_i,
  ssc_in_if.sink          in_i,
  ssc_out_if.source       out_o
);

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  logic [ValW-1:0]  max_value_q;
  logic             mem_wr_en;
  logic [AddrW-1:0] mem_wr_addr;
  run_t             mem_wr_run;
  logic             mem_rd_en;
  logic [AddrW-1:0] mem_rd_addr;
  run_t             mem_rd_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= MaxValueRst;
    end else if (cfg_we_i) begin
      max_value_q <= cfg_wdata_i;
    end
  end

  ssc_ctrl #(
    .StackDepth (STACK_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_value_i   (max_value_q),
    .in_i          (in_i),
    .out_o         (out_o),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_run_o  (mem_wr_run),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_run_i  (mem_rd_run)
  );

  ssc_run_mem #(
    .Depth (STACK_DEPTH)
  ) u_run_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_run_i  (mem_wr_run),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_run_o  (mem_rd_run)
  );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import ssc_pkg::*;

  typedef struct {
    logic [ValW-1:0] value;
    logic            first;
  } wanted_t;

  typedef struct {
    logic [ValW-1:0] push_count;
    logic            popped;
    logic            failed;
  } pop_result_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [ValW-1:0] cfg_wdata_i = '0;

  ssc_in_if  in_if();
  ssc_out_if out_if();

  stack_sequence_checker_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [ValW-1:0] model_stack [StackDepthDef];
  int unsigned     model_depth = 0;
  int unsigned     model_last = 0;
  bit              model_failed = 1'b0;
  int unsigned     max_value_q = MaxValueRst;

  wanted_t     want_q[$];
  pop_result_t pop_result_q[$];
  int unsigned mismatches = 0;

  function automatic pop_result_t serve_wanted(logic [ValW-1:0] want, logic first);
    pop_result_t r;
    int unsigned limit;
    int unsigned pushes;
    bit          ok;
    pushes = 0;
    ok = 1'b0;
    if (first) begin
      model_depth = 0;
      model_last = 0;
      model_failed = 1'b0;
    end
    limit = (max_value_q > StackDepthDef) ? StackDepthDef : max_value_q;
    if (want > model_last) begin
      if (want <= limit) begin
        while (model_last < want && model_depth < StackDepthDef) begin
          model_last++;
          model_stack[model_depth] = ValW'(model_last);
          model_depth++;
          pushes++;
        end
        if (model_depth > 0 && model_stack[model_depth-1] == want) begin
          model_depth--;
          ok = 1'b1;
        end
      end
    end else if (model_depth > 0 && model_stack[model_depth-1] == want) begin
      model_depth--;
      ok = 1'b1;
    end
    if (!ok) model_failed = 1'b1;
    r.push_count = ValW'(pushes);
    r.popped = ok;
    r.failed = model_failed;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // input driver: bursts of random length with random gaps
  wanted_t     beat;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.value <= '0;
      in_if.first_item <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left != 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (want_q.size() != 0) begin
        beat = want_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.value <= beat.value;
        in_if.first_item <= beat.first;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // output stall pattern, mode redrawn whenever cyc[6:0] is zero
  logic [31:0] cyc = '0;
  logic [1:0]  stall_mode = '0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      cyc <= '0;
      stall_mode <= '0;
    end else begin
      cyc <= cyc + 1;
      if (cyc[6:0] == 0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0: out_if.ready <= 1'b1;
        2'd1: out_if.ready <= 1'($urandom_range(0, 1));
        2'd2: out_if.ready <= (cyc[1:0] == 2'd0);
        default: out_if.ready <= (cyc[4:0] >= 5'd20);
      endcase
    end
  end

  // monitor: predict on accepted input beats, check accepted result beats
  pop_result_t exp_res;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        pop_result_q.push_back(serve_wanted(in_if.value, in_if.first_item));
      if (out_if.valid && out_if.ready) begin
        if (pop_result_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          exp_res = pop_result_q.pop_front();
          if (out_if.push_count !== exp_res.push_count)
            report_mismatch($sformatf("push_count %0d, expected %0d",
                                      out_if.push_count, exp_res.push_count));
          if (out_if.popped !== exp_res.popped)
            report_mismatch($sformatf("popped %b, expected %b",
                                      out_if.popped, exp_res.popped));
          if (out_if.failed !== exp_res.failed)
            report_mismatch($sformatf("failed %b, expected %b",
                                      out_if.failed, exp_res.failed));
        end
      end
    end
  end

  task automatic push_want(int unsigned v, bit f);
    want_q.push_back('{value: ValW'(v), first: f});
  endtask

  task automatic wait_idle();
    while (want_q.size() != 0 || in_if.valid || pop_result_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_value(int unsigned v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= ValW'(v);
    max_value_q = v & 32'h7FF;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // a valid pop order of 1..n, optionally spoiled at one spot
  task automatic add_pop_sequence(int unsigned n, bit broken);
    int unsigned vals[$];
    int unsigned stk[$];
    int unsigned nxt;
    int unsigned k;
    int unsigned idx;
    int unsigned tmp;
    nxt = 1;
    while (vals.size() < n) begin
      if (stk.size() == 0 || (nxt <= n && $urandom_range(0, 2) == 0)) begin
        k = $urandom_range(1, (n - nxt + 1 > 6) ? 6 : n - nxt + 1);
        if ($urandom_range(0, 9) == 0) k = $urandom_range(1, n - nxt + 1);
        repeat (k) begin
          stk.push_back(nxt);
          nxt++;
        end
      end
      vals.push_back(stk.pop_back());
    end
    if (broken && n > 1) begin
      idx = $urandom_range(0, n - 2);
      case ($urandom_range(0, 2))
        0: begin
          tmp = vals[idx];
          vals[idx] = vals[idx+1];
          vals[idx+1] = tmp;
        end
        1: vals[idx] = $urandom_range(0, n + 2);
        default: vals[idx] = 0;
      endcase
    end
    foreach (vals[i]) push_want(vals[i], i == 0);
  endtask

  task automatic fill_phase(int unsigned budget);
    int unsigned eff;
    int unsigned cap;
    int unsigned n;
    int unsigned r;
    eff = (max_value_q > StackDepthDef) ? StackDepthDef : max_value_q;
    while (want_q.size() < budget) begin
      r = $urandom_range(0, 9);
      if (eff == 0 || r < 2) begin
        // noise beats, some near the limit
        if ($urandom_range(0, 1) == 0)
          push_want($urandom_range(0, 2047), $urandom_range(0, 3) == 0);
        else
          push_want((eff + $urandom_range(0, 2)) & 32'h7FF, $urandom_range(0, 3) == 0);
      end else begin
        cap = (eff < 24) ? eff : 24;
        n = $urandom_range(1, cap);
        if ($urandom_range(0, 19) == 0) n = $urandom_range(1, (eff < 200) ? eff : 200);
        add_pop_sequence(n, r == 2);
      end
    end
  endtask

  initial begin
    int unsigned settings[$];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset max_value
    push_want(1024, 1'b1);  // push everything at once
    push_want(1023, 1'b0);
    push_want(1, 1'b0);     // below the top
    push_want(1022, 1'b0);  // pops but failure stays
    push_want(2047, 1'b1);  // above max_value
    push_want(0, 1'b1);     // zero is never on the stack
    push_want(1, 1'b1);
    push_want(1, 1'b0);     // already pushed, stack empty
    push_want(3, 1'b1);
    push_want(1, 1'b0);
    push_want(2, 1'b0);
    push_want(1, 1'b0);
    push_want(4, 1'b0);
    push_want(1025, 1'b1);
    wait_idle();

    write_max_value(5);
    push_want(5, 1'b1);
    push_want(6, 1'b0);     // beyond the new limit
    push_want(4, 1'b0);
    push_want(3, 1'b0);
    wait_idle();

    write_max_value(2047);  // limit clamps to the stack depth
    push_want(1024, 1'b1);
    push_want(1025, 1'b0);
    push_want(1023, 1'b0);
    wait_idle();

    // random phases over several limits
    settings = '{1024, 1, 2047, 0, $urandom_range(3, 1023), 1025, 1024,
                 $urandom_range(2, 40), 2};
    foreach (settings[i]) begin
      write_max_value(settings[i]);
      fill_phase(170);
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
